FILE: sv/aabb_refit_pkg.sv
// Package for the AABB hierarchy refit block: box type, widths, state codes
// and the box union function. No dependencies.
`default_nettype none
package aabb_refit_pkg;

   localparam int NODE_BITS  = 8;
   localparam int MAX_NODES  = 1 << NODE_BITS;
   localparam int COORD_BITS = 32;
   localparam int AXES       = 3;

   localparam int REQ_DATA_BITS = 2 * NODE_BITS + 2 * AXES * COORD_BITS;
   localparam int RSP_DATA_BITS = NODE_BITS + 2 * AXES * COORD_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic                  valid;
      logic [AXES-1:0][COORD_BITS-1:0] lo;
      logic [AXES-1:0][COORD_BITS-1:0] hi;
   } box_type;

   localparam box_type EMPTY_BOX = '0;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MERGE  = 3'b010,
      ST_PARENT = 3'b100
   } state_type;

   // Union of src into dst: an empty src adds nothing, an empty dst takes src.
   function automatic box_type box_union(input box_type dst, input box_type src);
      box_type res;
      res = dst;
      if (src.valid && !dst.valid) begin
         res = src;
      end else if (src.valid) begin
         for (int i = 0; i < AXES; i++) begin
            if ($signed(src.lo[i]) < $signed(dst.lo[i])) res.lo[i] = src.lo[i];
            if ($signed(src.hi[i]) > $signed(dst.hi[i])) res.hi[i] = src.hi[i];
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: sv/aabb_hierarchy_refit.sv
// Top level of the AABB hierarchy refit block: box memory, clear tags and
// the three-step sequencer. Depends on aabb_refit_pkg.
`default_nettype none
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  node, parent, object box; obj_valid on tuser
// rsp      out  rsp_tvalid/rsp_tready  handle, world box; box_valid on tuser,
//                                      pass_done on tlast
//
// Each item passes three steps: accept (both memory reads issued), merge
// (node box computed and written back), parent (parent box written back unless
// the node is root or its own parent; result loaded). One write port serves both.
// Synchronous reset sets every clear tag, so no clearing pass is needed; the
// memory itself is never reset. A result held in the output register stalls
// the parent step only; the next item is taken as soon as the parent step ends.
module aabb_hierarchy_refit (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // node_handle[7:0], parent_handle[15:8], obj_min_x/y/z, obj_max_x/y/z (32 each)
   input  wire logic [aabb_refit_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // obj_valid[0]
   input  wire logic req_tuser,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // out_handle[7:0], box_min_x/y/z, box_max_x/y/z (32 each)
   output logic [aabb_refit_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // box_valid[0]
   output logic      rsp_tuser,
   // pass_done
   output logic      rsp_tlast
);
   import aabb_refit_pkg::*;

   localparam int LO_BASE = 2 * NODE_BITS;
   localparam int HI_BASE = LO_BASE + AXES * COORD_BITS;

   state_type state_ff, state_in;

   logic [NODE_BITS-1:0] node_ff, node_in;
   logic [NODE_BITS-1:0] parent_ff, parent_in;
   box_type              obj_ff, obj_in;
   box_type              node_box_ff, node_box_in;

   logic [MAX_NODES-1:0] pend_ff, pend_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;
   logic                 rsp_last_ff, rsp_last_in;

   // box memory, two registered read ports and one write port
   box_type              box_mem [MAX_NODES];
   box_type              rd_node_ff, rd_parent_ff;
   logic                 wr_en;
   logic [NODE_BITS-1:0] wr_addr;
   box_type              wr_data;

   logic    accept;
   logic    advance;
   logic    is_root;
   box_type node_old;
   box_type parent_old;
   box_type parent_new;
   box_type req_box;
   box_type out_box;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_root    = (node_ff == '0);
   // the parent step may finish once the output register is free
   assign advance    = (state_ff == ST_PARENT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      req_box.valid = req_tuser;
      for (int i = 0; i < AXES; i++) begin
         req_box.lo[i] = req_tdata[LO_BASE + i*COORD_BITS +: COORD_BITS];
         req_box.hi[i] = req_tdata[HI_BASE + i*COORD_BITS +: COORD_BITS];
      end
   end

   // drop stale contents of entries still tagged for clearing
   assign node_old   = pend_ff[node_ff] ? EMPTY_BOX : rd_node_ff;
   assign parent_old = pend_ff[parent_ff] ? EMPTY_BOX : rd_parent_ff;
   assign parent_new = box_union(parent_old, node_box_ff);

   always_comb begin
      out_box = node_box_ff;
      if (!node_box_ff.valid) begin
         out_box = EMPTY_BOX;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = node_ff;
      wr_data = node_box_in;
      if (state_ff == ST_MERGE) begin
         wr_en = 1'b1;
      end else if (advance && !is_root && (parent_ff != node_ff)) begin
         wr_en   = 1'b1;
         wr_addr = parent_ff;
         wr_data = parent_new;
      end
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      parent_in    = parent_ff;
      obj_in       = obj_ff;
      node_box_in  = node_box_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               node_in   = req_tdata[NODE_BITS-1:0];
               parent_in = req_tdata[2*NODE_BITS-1:NODE_BITS];
               obj_in    = req_box;
               state_in  = ST_MERGE;
            end
         end
         ST_MERGE: begin
            node_box_in      = box_union(node_old, obj_ff);
            pend_in[node_ff] = 1'b0;
            state_in         = ST_PARENT;
         end
         ST_PARENT: begin
            if (advance) begin
               if (is_root) begin
                  pend_in = '1;
               end else begin
                  pend_in[parent_ff] = 1'b0;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {out_box.hi[2], out_box.hi[1], out_box.hi[0],
                               out_box.lo[2], out_box.lo[1], out_box.lo[0], node_ff};
               rsp_user_in  = node_box_ff.valid;
               rsp_last_in  = is_root;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff     <= node_in;
      parent_ff   <= parent_in;
      obj_ff      <= obj_in;
      node_box_ff <= node_box_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // read both entries at accept; hold the read data through the item
   always_ff @(posedge clock) begin
      if (wr_en) begin
         box_mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rd_node_ff   <= box_mem[req_tdata[NODE_BITS-1:0]];
         rd_parent_ff <= box_mem[req_tdata[2*NODE_BITS-1:NODE_BITS]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire
